>>> rtl/core/isas_pkg.sv
// ----------------------------------------------------------------------------
// isas_pkg
// Shared constants, codes and types of the indexed shift array store.
// ----------------------------------------------------------------------------
package isas_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 12;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ      = 3'd0,
        CMD_WRITE     = 3'd1,
        CMD_APPEND    = 3'd2,
        CMD_INSERT    = 3'd3,
        CMD_REM_LAST  = 3'd4,
        CMD_REM_AT    = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Port request from the sequencer to the entry memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // One finished result word, handed to the output register.
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
    } t_res;

endpackage

>>> rtl/core/isas_cmd_if.sv
// ----------------------------------------------------------------------------
// isas_cmd_if
// Command channel: valid/ready handshake with command, index and value.
// ----------------------------------------------------------------------------
interface isas_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [isas_pkg::CMD_W-1:0]          command;
    logic signed [isas_pkg::IDX_W-1:0]   index;
    logic signed [isas_pkg::DATA_W-1:0]  value;

    modport source (output valid, output command, output index, output value,
                    input ready);
    modport sink   (input valid, input command, input index, input value,
                    output ready);
endinterface

>>> rtl/core/isas_res_if.sv
// ----------------------------------------------------------------------------
// isas_res_if
// Result channel: valid/ready handshake with data, status, count and flag.
// ----------------------------------------------------------------------------
interface isas_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [isas_pkg::DATA_W-1:0]  data;
    logic [isas_pkg::STATUS_W-1:0]       status;
    logic [isas_pkg::COUNT_W-1:0]        count;
    logic                                empty_res;

    modport source (output valid, output data, output status, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input data, input status, input count,
                    input empty_res, output ready);
endinterface

>>> rtl/core/isas_ram.sv
// ----------------------------------------------------------------------------
// isas_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module isas_ram (
    input  logic                            i_clk,
    input  isas_pkg::t_ram_req              i_req,
    output logic [isas_pkg::DATA_W-1:0]     o_rdata
);

    logic [isas_pkg::DATA_W-1:0] mem [isas_pkg::CAPACITY];
    logic [isas_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/isas_ctrl.sv
// ----------------------------------------------------------------------------
// isas_ctrl
// Command decode, live count and the read-modify-write shift sequencer.
// ----------------------------------------------------------------------------
module isas_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    isas_cmd_if.sink                        i_cmd,
    output isas_pkg::t_ram_req              o_req,
    input  logic [isas_pkg::DATA_W-1:0]     i_rdata,
    output isas_pkg::t_res                  o_res,
    output logic                            o_res_load,
    input  logic                            i_res_free
);

    localparam int A = isas_pkg::ADDR_W;
    localparam int C = isas_pkg::COUNT_W;
    localparam int P = isas_pkg::IDX_W + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [C-1:0]                   r_count, n_count;
    logic [C-1:0]                   r_new_count, n_new_count;
    isas_pkg::t_cmd                 r_cmd, n_cmd;
    logic [A-1:0]                   r_slot, n_slot;
    logic [isas_pkg::DATA_W-1:0]    r_val, n_val;
    logic [isas_pkg::DATA_W-1:0]    r_data, n_data;
    isas_pkg::t_status              r_status, n_status;
    logic [A-1:0]                   r_rptr, n_rptr;
    logic [C-1:0]                   r_rleft, n_rleft;
    logic                           r_pend, n_pend;
    logic [A-1:0]                   r_paddr, n_paddr;

    logic                           accept;
    logic                           neg;
    logic signed [P-1:0]            pos_s, cnt_s, adj;
    logic                           rd_ok, wr_ok, ins_ok, full;
    logic [A-1:0]                   rd_slot;
    logic                           down;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Index resolution against the live count, in one bit more than the index.
    assign neg     = i_cmd.index[isas_pkg::IDX_W-1];
    assign pos_s   = {neg, i_cmd.index};
    assign cnt_s   = signed'({{(P - C){1'b0}}, r_count});
    assign adj     = pos_s + cnt_s;
    assign rd_ok   = neg ? !adj[P-1] : (pos_s < cnt_s);
    assign rd_slot = neg ? adj[A-1:0] : pos_s[A-1:0];
    assign wr_ok   = !neg && (pos_s < cnt_s);
    assign ins_ok  = !neg && (pos_s <= cnt_s);
    assign full    = (r_count >= C'(isas_pkg::CAPACITY));
    assign down    = (r_cmd == isas_pkg::CMD_INSERT);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_new_count = r_new_count;
        n_cmd       = r_cmd;
        n_slot      = r_slot;
        n_val       = r_val;
        n_data      = r_data;
        n_status    = r_status;
        n_rptr      = r_rptr;
        n_rleft     = r_rleft;
        n_pend      = 1'b0;
        n_paddr     = r_paddr;
        o_req       = '0;
        o_res_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd       = isas_pkg::t_cmd'(i_cmd.command);
                    n_val       = i_cmd.value;
                    n_data      = '0;
                    n_status    = isas_pkg::ST_DONE;
                    n_new_count = r_count;
                    n_state     = S_DONE;
                    case (isas_pkg::t_cmd'(i_cmd.command))
                        isas_pkg::CMD_READ: begin
                            if (rd_ok) begin
                                o_req.re    = 1'b1;
                                o_req.raddr = rd_slot;
                                n_state     = S_FETCH;
                            end else begin
                                n_data   = '1;
                                n_status = isas_pkg::ST_RANGE;
                            end
                        end
                        isas_pkg::CMD_WRITE: begin
                            if (wr_ok) begin
                                o_req.we    = 1'b1;
                                o_req.waddr = pos_s[A-1:0];
                                o_req.wdata = i_cmd.value;
                            end else begin
                                n_status = isas_pkg::ST_RANGE;
                            end
                        end
                        isas_pkg::CMD_APPEND: begin
                            if (full) begin
                                n_status = isas_pkg::ST_FULL;
                            end else begin
                                o_req.we    = 1'b1;
                                o_req.waddr = r_count[A-1:0];
                                o_req.wdata = i_cmd.value;
                                n_new_count = r_count + 1'b1;
                            end
                        end
                        isas_pkg::CMD_INSERT: begin
                            if (!ins_ok) begin
                                n_status = isas_pkg::ST_RANGE;
                            end else if (full) begin
                                n_status = isas_pkg::ST_FULL;
                            end else begin
                                // Shift downwards from the last entry to the slot.
                                n_slot      = pos_s[A-1:0];
                                n_rptr      = r_count[A-1:0] - 1'b1;
                                n_rleft     = r_count - pos_s[C-1:0];
                                n_new_count = r_count + 1'b1;
                                n_state     = S_SHIFT;
                            end
                        end
                        isas_pkg::CMD_REM_LAST: begin
                            if (r_count == '0) begin
                                n_status = isas_pkg::ST_RANGE;
                            end else begin
                                o_req.re    = 1'b1;
                                o_req.raddr = r_count[A-1:0] - 1'b1;
                                n_new_count = r_count - 1'b1;
                                n_state     = S_FETCH;
                            end
                        end
                        isas_pkg::CMD_REM_AT: begin
                            if (rd_ok) begin
                                o_req.re    = 1'b1;
                                o_req.raddr = rd_slot;
                                n_slot      = rd_slot;
                                n_rptr      = rd_slot + 1'b1;
                                n_rleft     = r_count - {1'b0, rd_slot} - 1'b1;
                                n_new_count = r_count - 1'b1;
                                n_state     = S_FETCH;
                            end else begin
                                n_status = isas_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_data  = i_rdata;
                n_state = (r_cmd == isas_pkg::CMD_REM_AT) ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                // Read one entry ahead while the entry read last cycle is
                // written one place over; the two addresses never meet.
                if (r_rleft != '0) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = r_rptr;
                    n_rptr      = down ? r_rptr - 1'b1 : r_rptr + 1'b1;
                    n_rleft     = r_rleft - 1'b1;
                    n_pend      = 1'b1;
                    n_paddr     = r_rptr;
                end
                if (r_pend) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = down ? r_paddr + 1'b1 : r_paddr - 1'b1;
                    o_req.wdata = i_rdata;
                end else if (r_rleft == '0) begin
                    if (down) begin
                        o_req.we    = 1'b1;
                        o_req.waddr = r_slot;
                        o_req.wdata = r_val;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    n_count    = r_new_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.data      = r_data;
    assign o_res.status    = r_status;
    assign o_res.count     = r_new_count;
    assign o_res.empty_res = (r_new_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_count <= n_new_count;
        r_cmd       <= n_cmd;
        r_slot      <= n_slot;
        r_val       <= n_val;
        r_data      <= n_data;
        r_status    <= n_status;
        r_rptr      <= n_rptr;
        r_rleft     <= n_rleft;
        r_paddr     <= n_paddr;
    end

endmodule

>>> rtl/core/indexed_shift_array_store.sv
// ----------------------------------------------------------------------------
// indexed_shift_array_store
// Ordered store of signed 32-bit words with read, write, append, insert and
// removal by index, backed by one synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel   Direction   Word contents
//  i_cmd     in          command, index, value
//  o_res     out         data, status, count, empty_res
//
// Path from the accepting edge to the result word being loaded: write,
// append, unused codes and rejected commands go straight to the done state;
// read and remove-last pass through the memory fetch state first; insert
// runs the shift loop, and remove-at the fetch state and then the shift loop.
// The shift loop does one memory read and one write per cycle. The next
// command is taken in the cycle after the load at the earliest.
// Reset clears the count and the control state only; the entry memory keeps
// whatever it holds, since no entry beyond the count is ever read.
// A result word waits in the output register while a further command is
// accepted and worked on; that command holds its result until the register
// has been emptied.
// ----------------------------------------------------------------------------
module indexed_shift_array_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isas_cmd_if.sink    i_cmd,
    isas_res_if.source  o_res
);

    isas_pkg::t_ram_req             ram_req;
    logic [isas_pkg::DATA_W-1:0]    ram_rdata;
    isas_pkg::t_res                 res;
    logic                           res_load;
    logic                           res_free;

    // The sequencer may hand over a result when the output register is empty
    // or is being emptied at this very edge.
    assign res_free = !o_res.valid || o_res.ready;

    isas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .o_req      (ram_req),
        .i_rdata    (ram_rdata),
        .o_res      (res),
        .o_res_load (res_load),
        .i_res_free (res_free)
    );

    isas_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Output register: valid is control state, the payload is loaded only.
    logic           r_out_valid;
    isas_pkg::t_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.data      = r_out.data;
    assign o_res.status    = r_out.status;
    assign o_res.count     = r_out.count;
    assign o_res.empty_res = r_out.empty_res;

endmodule

>>> rtl/core/isas_chk.sv
// ----------------------------------------------------------------------------
// isas_chk
// Port-level checks of the indexed shift array store, bound to the top level.
// ----------------------------------------------------------------------------
module isas_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_res_valid,
    input logic                             i_res_ready,
    input logic [isas_pkg::DATA_W-1:0]      i_res_data,
    input logic [isas_pkg::STATUS_W-1:0]    i_res_status,
    input logic [isas_pkg::COUNT_W-1:0]     i_res_count,
    input logic                             i_res_empty
);

    localparam logic [isas_pkg::COUNT_W-1:0] CAP =
        isas_pkg::COUNT_W'(isas_pkg::CAPACITY);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data)
            && $stable(i_res_status) && $stable(i_res_count))
        else $error("result word changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_empty == (i_res_count == '0)))
        else $error("empty flag disagrees with count");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_count <= CAP))
        else $error("count above capacity");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == isas_pkg::ST_FULL) |-> (i_res_count == CAP))
        else $error("full status with spare room");

endmodule

bind indexed_shift_array_store isas_chk u_isas_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_data   (o_res.data),
    .i_res_status (o_res.status),
    .i_res_count  (o_res.count),
    .i_res_empty  (o_res.empty_res)
);

>>> bench/isas_result_checker.sv
// ----------------------------------------------------------------------------
// isas_result_checker
// Keeps a shadow copy of the store, works out the result word of every
// accepted command and compares it field by field with the word that leaves.
// ----------------------------------------------------------------------------
module isas_result_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    isas_cmd_if   i_cmd,
    isas_res_if   i_res,
    output int    o_fail_count,
    output int    o_level,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import isas_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [DATA_W-1:0] shadow_words [CAPACITY];
    int                shadow_count = 0;
    t_res              expected_words [$];
    int                mismatches   = 0;
    int                words_seen   = 0;

    // Turns a signed position into a live slot; negative positions count
    // back from the end only where the command allows it.
    function automatic bit locate_entry(input int pos, input bit from_end,
                                        output int slot);
        slot = 0;
        if (pos < 0) begin
            if (!from_end || pos < -shadow_count) return 1'b0;
            pos += shadow_count;
        end
        if (pos >= shadow_count) return 1'b0;
        slot = pos;
        return 1'b1;
    endfunction

    // Applies one command to the shadow store and returns its result word.
    function automatic t_res apply_command(input logic [CMD_W-1:0] cmd,
                                           input logic signed [IDX_W-1:0] idx,
                                           input logic [DATA_W-1:0] val);
        t_res r;
        int   pos;
        int   slot;
        int   i;
        r.data   = '0;
        r.status = ST_DONE;
        pos      = idx;
        case (cmd)
            CMD_READ: begin
                if (locate_entry(pos, 1'b1, slot)) begin
                    r.data = shadow_words[slot];
                end else begin
                    r.data   = '1;
                    r.status = ST_RANGE;
                end
            end
            CMD_WRITE: begin
                if (locate_entry(pos, 1'b0, slot)) shadow_words[slot] = val;
                else r.status = ST_RANGE;
            end
            CMD_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_count] = val;
                    shadow_count++;
                end
            end
            CMD_INSERT: begin
                // The position is checked before fullness.
                if (pos < 0 || pos > shadow_count) begin
                    r.status = ST_RANGE;
                end else if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = val;
                    shadow_count++;
                end
            end
            CMD_REM_LAST: begin
                if (shadow_count == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    shadow_count--;
                    r.data = shadow_words[shadow_count];
                end
            end
            CMD_REM_AT: begin
                if (locate_entry(pos, 1'b1, slot)) begin
                    r.data = shadow_words[slot];
                    for (i = slot; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        r.count     = COUNT_W'(shadow_count);
        r.empty_res = (shadow_count == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_words.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("isas check: result word %0d arrived with none expected",
                                 words_seen);
                end else begin
                    want = expected_words.pop_front();
                    if (i_res.data !== want.data || i_res.status !== want.status ||
                        i_res.count !== want.count ||
                        i_res.empty_res !== want.empty_res) begin
                        mismatches++;
                        // Fields in order: data, status, count, empty flag.
                        if (mismatches <= REPORT_LIMIT)
                            $display("isas check: word %0d want %h/%0d/%0d/%0b got %h/%0d/%0d/%0b",
                                     words_seen, want.data, want.status, want.count,
                                     want.empty_res, i_res.data, i_res.status,
                                     i_res.count, i_res.empty_res);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_words.push_back(apply_command(i_cmd.command, i_cmd.index,
                                                       i_cmd.value));
        end
        o_fail_count <= mismatches;
        o_level      <= shadow_count;
        o_pending    <= expected_words.size();
    end

endmodule

>>> bench/tb_indexed_shift_array_store.sv
// ----------------------------------------------------------------------------
// tb_indexed_shift_array_store
// Drives commands into the indexed shift array store and collects its result
// words, with random gaps and stalls on both channels; a checker instance
// beside the block predicts every result word and counts the mismatches.
// ----------------------------------------------------------------------------
module tb_indexed_shift_array_store;
    timeunit 1ns;
    timeprecision 1ps;

    import isas_pkg::*;

    // Command codes that the block does not decode; each still gives a word.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int RANDOM_WORDS = 580;
    // Longest shift plus pipeline, rounded up, with room for a full stall.
    localparam int SETTLE_CYCLES = 1100;
    localparam int DRAIN_LIMIT   = 20000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int model_level;
    int pending;

    bit cmd_burst = 1'b0;
    bit res_burst = 1'b0;

    isas_cmd_if cmd_ch ();
    isas_res_if res_ch ();

    indexed_shift_array_store i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    isas_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_level      (model_level),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    // Reset is held low at the start and then released for good.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #150_000_000;
        $display("[indexed_shift_array_store] ERROR");
        $finish;
    end

    // Result side. Before each word the sink holds ready low for a random
    // number of cycles; now and then it switches into a stretch with no
    // stalls at all. Ready is only lowered when the coming stall is non-zero,
    // so a back-to-back accept never sees ready fall and rise in one step.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 23) == 0) res_burst = !res_burst;
            stall = res_burst ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Offers one command word after a random gap and waits until it has been
    // taken. Valid is left high when the next word follows straight away.
    // The position is given as an integer and cut to the field here.
    task automatic send_word(input logic [CMD_W-1:0] c, input int ix,
                             input logic [DATA_W-1:0] v);
        int gap;
        if ($urandom_range(0, 23) == 0) cmd_burst = !cmd_burst;
        gap = cmd_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.index   <= ix[IDX_W-1:0];
        cmd_ch.value   <= v;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    // The fill level steers the mix: a nearly empty store mostly grows and a
    // longer one mostly shrinks, so the count wanders between a handful and
    // a few dozen entries and the shifts stay short.
    function automatic logic [CMD_W-1:0] pick_command(input int level);
        int roll;
        int grow_pct;
        roll     = $urandom_range(0, 99);
        grow_pct = (level < 8) ? 75 : (level > 56) ? 25 : 50;
        if (roll < 3) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
        if (roll < 20) return CMD_READ;
        if (roll < 32) return CMD_WRITE;
        if ($urandom_range(0, 99) < grow_pct)
            return ($urandom_range(0, 1) != 0) ? CMD_APPEND : CMD_INSERT;
        return ($urandom_range(0, 1) != 0) ? CMD_REM_LAST : CMD_REM_AT;
    endfunction

    // Mostly a position that names a live entry (or, for insert, a legal
    // gap), some just past either end, and some anywhere in the field.
    function automatic int pick_index(input logic [CMD_W-1:0] c, input int level);
        int roll;
        int k;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            k = $urandom();
        end else if (roll < 35) begin
            case ($urandom_range(0, 3))
                0:       k = level;
                1:       k = level + 1;
                2:       k = -level - 1;
                default: k = -level;
            endcase
        end else if (c == CMD_INSERT) begin
            k = $urandom_range(0, level);
        end else if (level == 0) begin
            k = 0;
        end else if ((c == CMD_READ || c == CMD_REM_AT) && $urandom_range(0, 1) != 0) begin
            k = -int'($urandom_range(1, level));
        end else begin
            k = $urandom_range(0, level - 1);
        end
        return k;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return ($urandom_range(0, 1) != 0) ? '0 : '1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int roll;
        int waited;
        logic [CMD_W-1:0] c;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= '0;
        cmd_ch.index   <= '0;
        cmd_ch.value   <= '0;
        while (!i_rst_n) @(posedge i_clk);

        // Everything that can fail on an empty store, and the spare codes.
        send_word(CMD_READ, 0, 0);
        send_word(CMD_READ, -1, 0);
        send_word(CMD_REM_LAST, 0, 0);
        send_word(CMD_REM_AT, 0, 0);
        send_word(CMD_WRITE, 0, 32'h1234_5678);
        send_word(CMD_INSERT, 1, 32'h1111_1111);
        send_word(CMD_INSERT, -1, 32'h2222_2222);
        send_word(CMD_SPARE_A, 0, 32'hFFFF_FFFF);
        send_word(CMD_SPARE_B, -1, 32'hFFFF_FFFF);

        // Build five entries: both word extremes, a prepend, an insert at
        // the count (which appends) and one in the middle.
        send_word(CMD_APPEND, 0, 32'h7FFF_FFFF);
        send_word(CMD_APPEND, 0, 32'h8000_0000);
        send_word(CMD_INSERT, 0, 32'h0000_0000);
        send_word(CMD_INSERT, 3, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 1, 32'h5A5A_5A5A);

        // Negative positions down to minus the count, and just beyond.
        send_word(CMD_READ, -1, 0);
        send_word(CMD_READ, -5, 0);
        send_word(CMD_READ, -6, 0);
        send_word(CMD_READ, 5, 0);
        send_word(CMD_READ, -2048, 0);
        send_word(CMD_READ, 2047, 0);

        // A write never counts from the end.
        send_word(CMD_WRITE, 0, 32'hA5A5_A5A5);
        send_word(CMD_WRITE, -1, 32'h3333_3333);
        send_word(CMD_WRITE, 5, 32'h4444_4444);

        send_word(CMD_REM_AT, -1, 0);
        send_word(CMD_REM_AT, 1, 0);
        send_word(CMD_REM_AT, -4, 0);
        send_word(CMD_REM_LAST, 0, 0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            c = pick_command(model_level);
            send_word(c, pick_index(c, model_level), pick_value());
        end

        // Fill the store to capacity, mainly by appending. The level seen
        // here may lag by one word, which at worst adds an append when full.
        while (model_level < CAPACITY) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_word(CMD_INSERT, $urandom_range(0, model_level), pick_value());
            else if (roll < 8)
                send_word(CMD_READ, pick_index(CMD_READ, model_level), 0);
            else
                send_word(CMD_APPEND, 0, pick_value());
        end

        // A full store: rejected growth, with the insert position checked
        // ahead of fullness, and positions at both ends of the whole range.
        send_word(CMD_APPEND, 0, pick_value());
        send_word(CMD_INSERT, 0, pick_value());
        send_word(CMD_INSERT, CAPACITY, pick_value());
        send_word(CMD_INSERT, CAPACITY + 1, pick_value());
        send_word(CMD_INSERT, -1, pick_value());
        send_word(CMD_READ, -CAPACITY, 0);
        send_word(CMD_READ, -CAPACITY - 1, 0);
        send_word(CMD_READ, CAPACITY - 1, 0);
        send_word(CMD_READ, CAPACITY, 0);
        send_word(CMD_WRITE, CAPACITY - 1, pick_value());
        send_word(CMD_WRITE, CAPACITY, pick_value());
        // Removing the first entry moves every other one down.
        send_word(CMD_REM_AT, -CAPACITY, 0);
        send_word(CMD_APPEND, 0, pick_value());
        send_word(CMD_REM_AT, CAPACITY - 1, 0);
        send_word(CMD_REM_LAST, 0, 0);

        // Drain back to empty, with the odd read or long removal on the way.
        while (model_level > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_word(CMD_REM_AT, pick_index(CMD_REM_AT, model_level), 0);
            else if (roll < 5)
                send_word(CMD_READ, pick_index(CMD_READ, model_level), 0);
            else
                send_word(CMD_REM_LAST, 0, 0);
        end
        send_word(CMD_REM_LAST, 0, 0);
        send_word(CMD_READ, 0, 0);
        cmd_ch.valid <= 1'b0;

        // First let the checker count the last command; then wait for
        // every expected word, and a while longer to catch strays.
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[indexed_shift_array_store] OK");
        end else begin
            $display("[indexed_shift_array_store] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/isas_pkg.sv
rtl/core/isas_cmd_if.sv
rtl/core/isas_res_if.sv
rtl/core/isas_ram.sv
rtl/core/isas_ctrl.sv
rtl/core/indexed_shift_array_store.sv
rtl/core/isas_chk.sv
bench/isas_result_checker.sv
bench/tb_indexed_shift_array_store.sv
